FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the displacement core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Constants, codes and shared types of the force layout displacement core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fld_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 33;
  localparam int MAG_W      = 33;
  localparam int DEN_W      = 66;
  localparam int KW_W       = 47;
  localparam int MULA_W     = 64 - FRAC_BITS;
  localparam int ACC_W      = 2 * FRAC_BITS + 49;
  localparam int CNT_W      = 6;
  localparam int MUL_STEPS  = 33;
  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 33;
  localparam int ATTR_MULT  = 10;

  localparam int EPS_RAW = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam logic [QUO_W-1:0] EPS = (EPS_RAW == 0) ? QUO_W'(1) : QUO_W'(EPS_RAW);
  localparam logic [QUO_W-1:0] M31 = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPUL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXST = 3'd4;

  localparam logic [1:0] OP_BEGIN    = 2'd0;
  localparam logic [1:0] OP_REPULSE  = 2'd1;
  localparam logic [1:0] OP_NEIGHBOR = 2'd2;
  localparam logic [1:0] OP_END      = 2'd3;

  typedef enum logic [1:0] {
    AM_MUL,
    AM_DIV,
    AM_SQRT
  } arith_mode_t;

  typedef struct packed {
    logic              start;
    arith_mode_t       mode;
    logic [ACC_W-1:0]  opa;
    logic [DEN_W-1:0]  opb;
  } fld_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              sat;
    logic [ACC_W-1:0]  prod;
    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] root;
  } fld_rsp_t;

endpackage

FILE: rtl/core/fld_chan_if.sv
// ----------------------------------------------------------------------------
// fld channel interfaces
// Valid/ready channels for particle items and displacement results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fld_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] weight;
  logic [15:0] neighbor_count;
  logic        frozen;

  modport source (output valid, op, pos_x, pos_y, weight, neighbor_count, frozen,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, weight, neighbor_count, frozen,
                output ready);
endinterface

interface fld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] disp_x;
  logic [31:0] disp_y;
  logic [30:0] step_length;
  logic [31:0] energy;
  logic        was_frozen;

  modport source (output valid, disp_x, disp_y, step_length, energy, was_frozen,
                  input ready);
  modport sink (input valid, disp_x, disp_y, step_length, energy, was_frozen,
                output ready);
endinterface

FILE: rtl/core/force_layout_displacement_core.sv
// ----------------------------------------------------------------------------
// force_layout_displacement_core
// Per-particle displacement of a force-directed layout step, Q16.16.
// ----------------------------------------------------------------------------
// Repulsor and neighbor items run up to ten operations on the shared
// multiply/divide/square-root unit; an end item runs further operations on
// it, more when the length clamp applies. A frozen particle's repulsor and
// neighbor items skip the unit and its end item goes straight to the emit
// state. in_ch.ready is high only while the sequencer is idle, and a finished
// result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module force_layout_displacement_core import fld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  fld_in_if.sink               in_ch,
  fld_out_if.source            out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DSQ, ST_KW, ST_RDIV, ST_KD, ST_A10,
    ST_ADIV, ST_CXM, ST_CXD, ST_CYM, ST_CYD, ST_SCX, ST_SCY, ST_CLXM,
    ST_CLXD, ST_CLYM, ST_CLYD, ST_EMIT
  } state_t;

  state_t            state_r;
  logic              go_r;
  logic [1:0]        op_r;
  logic [CFG_W-1:0]  ideal_r, attr_r, repul_r, scale_r, maxst_r;
  logic [31:0]       own_x_r, own_y_r, sum_x_r, sum_y_r, energy_r;
  logic              frozen_r;
  logic [15:0]       weight_r, count_r;
  logic [MAG_W-1:0]  ax_r, ay_r;
  logic              xneg_r, yneg_r, tneg_r;
  logic [DEN_W-1:0]  sq_r;
  logic [ROOT_W-1:0] len_r;
  logic [ACC_W-1:0]  tmp_r;
  logic [QUO_W-1:0]  factor_r;
  logic [31:0]       res_x_r, res_y_r;
  logic [CFG_W-1:0]  res_len_r;
  logic              res_frz_r;
  logic              out_valid_r;
  logic [31:0]       out_x_r, out_y_r, out_energy_r;
  logic [CFG_W-1:0]  out_len_r;
  logic              out_frz_r;

  fld_req_t          arith_req;
  fld_rsp_t          arith_rsp;

  logic              accept;
  logic              emit_ok;
  logic signed [MAG_W-1:0] dx_in, dy_in;
  logic [MAG_W-1:0]  ax_in, ay_in;
  logic [ROOT_W-1:0] ideal_ext;
  logic [ROOT_W-1:0] d_rep;
  logic              diff_neg;
  logic [ROOT_W-1:0] diff_mag;
  logic [31:0]       sum_mag_x, sum_mag_y;
  logic              cur_neg;
  logic [ACC_W-1:0]  scaled;
  logic [31:0]       sc_limit, sc_mag;
  logic [QUO_W-1:0]  quo_cap;

  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [QUO_W-1:0] m,
                                          input logic neg);
    logic signed [32:0] v;
    logic signed [32:0] t;
    t = {2'b00, m};
    v = $signed({s[31], s}) + (neg ? -t : t);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  fld_arith u_arith (
    .clk (clk),
    .rst_n (rst_n),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  assign accept  = in_ch.valid && in_ch.ready;
  assign emit_ok = !out_valid_r || out_ch.ready;

  assign dx_in = $signed({own_x_r[31], own_x_r}) - $signed({in_ch.pos_x[31], in_ch.pos_x});
  assign dy_in = $signed({own_y_r[31], own_y_r}) - $signed({in_ch.pos_y[31], in_ch.pos_y});
  assign ax_in = dx_in[MAG_W-1] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
  assign ay_in = dy_in[MAG_W-1] ? MAG_W'(-dy_in) : MAG_W'(dy_in);

  assign ideal_ext = ROOT_W'(ideal_r);
  assign d_rep     = (len_r < ideal_ext) ? ideal_ext : len_r;
  assign diff_neg  = len_r < ideal_ext;
  assign diff_mag  = diff_neg ? (ideal_ext - len_r) : (len_r - ideal_ext);

  assign sum_mag_x = sum_x_r[31] ? 32'(-sum_x_r) : sum_x_r;
  assign sum_mag_y = sum_y_r[31] ? 32'(-sum_y_r) : sum_y_r;
  assign cur_neg   = (state_r == ST_SCX) ? xneg_r : yneg_r;
  assign scaled    = arith_rsp.prod >> FRAC_BITS;
  assign sc_limit  = cur_neg ? 32'h8000_0000 : 32'h7fff_ffff;
  assign sc_mag    = (scaled > ACC_W'(sc_limit)) ? sc_limit : scaled[31:0];
  assign quo_cap   = arith_rsp.sat ? M31 : arith_rsp.quo;

  always_comb begin
    arith_req.start = go_r;
    arith_req.mode  = AM_MUL;
    arith_req.opa   = '0;
    arith_req.opb   = '0;
    case (state_r)
      ST_SQX: begin
        arith_req.opa = ACC_W'(ax_r);
        arith_req.opb = DEN_W'(ax_r);
      end
      ST_SQY: begin
        arith_req.opa = ACC_W'(ay_r);
        arith_req.opb = DEN_W'(ay_r);
      end
      ST_ROOT: begin
        arith_req.mode = AM_SQRT;
        arith_req.opb  = sq_r;
      end
      ST_DSQ: begin
        arith_req.opa = ACC_W'(d_rep);
        arith_req.opb = DEN_W'(d_rep);
      end
      ST_KW: begin
        arith_req.opa = ACC_W'(repul_r);
        arith_req.opb = DEN_W'(weight_r);
      end
      ST_RDIV: begin
        arith_req.mode = AM_DIV;
        arith_req.opa  = ACC_W'(tmp_r[KW_W-1:0]) << (2 * FRAC_BITS);
        arith_req.opb  = sq_r;
      end
      ST_KD: begin
        arith_req.opa = ACC_W'(attr_r);
        arith_req.opb = DEN_W'(diff_mag);
      end
      ST_A10: begin
        arith_req.opa = tmp_r >> FRAC_BITS;
        arith_req.opb = DEN_W'(ATTR_MULT);
      end
      ST_ADIV: begin
        arith_req.mode = AM_DIV;
        arith_req.opa  = tmp_r;
        arith_req.opb  = DEN_W'(count_r);
      end
      ST_CXM: begin
        arith_req.opa = ACC_W'(factor_r);
        arith_req.opb = DEN_W'(ax_r);
      end
      ST_CYM: begin
        arith_req.opa = ACC_W'(factor_r);
        arith_req.opb = DEN_W'(ay_r);
      end
      ST_CXD, ST_CYD, ST_CLXD, ST_CLYD: begin
        arith_req.mode = AM_DIV;
        arith_req.opa  = tmp_r;
        arith_req.opb  = DEN_W'(len_r);
      end
      ST_SCX: begin
        arith_req.opa = ACC_W'(sum_mag_x);
        arith_req.opb = DEN_W'(scale_r);
      end
      ST_SCY: begin
        arith_req.opa = ACC_W'(sum_mag_y);
        arith_req.opb = DEN_W'(scale_r);
      end
      ST_CLXM: begin
        arith_req.opa = ACC_W'(ax_r);
        arith_req.opb = DEN_W'(maxst_r);
      end
      ST_CLYM: begin
        arith_req.opa = ACC_W'(ay_r);
        arith_req.opb = DEN_W'(maxst_r);
      end
      default: begin
        arith_req.mode = AM_MUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      op_r        <= OP_BEGIN;
      ideal_r     <= CFG_W'(65536);
      attr_r      <= CFG_W'(65536);
      repul_r     <= CFG_W'(65536);
      scale_r     <= CFG_W'(65536);
      maxst_r     <= CFG_W'(6553600);
      own_x_r     <= '0;
      own_y_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      energy_r    <= '0;
      frozen_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDEAL: ideal_r <= cfg_wdata;
          CFG_ATTR:  attr_r  <= cfg_wdata;
          CFG_REPUL: repul_r <= cfg_wdata;
          CFG_SCALE: scale_r <= cfg_wdata;
          CFG_MAXST: maxst_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= in_ch.op;
            weight_r <= in_ch.weight;
            count_r  <= in_ch.neighbor_count;
            case (in_ch.op)
              OP_BEGIN: begin
                own_x_r  <= in_ch.pos_x;
                own_y_r  <= in_ch.pos_y;
                sum_x_r  <= '0;
                sum_y_r  <= '0;
                energy_r <= '0;
                frozen_r <= in_ch.frozen;
              end
              OP_REPULSE, OP_NEIGHBOR: begin
                if (!frozen_r && !(in_ch.op == OP_NEIGHBOR && in_ch.neighbor_count == '0))
                begin
                  ax_r    <= ax_in;
                  ay_r    <= ay_in;
                  xneg_r  <= dx_in[MAG_W-1];
                  yneg_r  <= dy_in[MAG_W-1];
                  state_r <= ST_SQX;
                  go_r    <= 1'b1;
                end
              end
              OP_END: begin
                if (frozen_r) begin
                  res_x_r   <= '0;
                  res_y_r   <= '0;
                  res_len_r <= '0;
                  res_frz_r <= 1'b1;
                  state_r   <= ST_EMIT;
                end else begin
                  xneg_r    <= sum_x_r[31];
                  yneg_r    <= sum_y_r[31];
                  res_frz_r <= 1'b0;
                  state_r   <= ST_SCX;
                  go_r      <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SQX: begin
          if (arith_rsp.done) begin
            sq_r    <= arith_rsp.prod[DEN_W-1:0];
            state_r <= ST_SQY;
            go_r    <= 1'b1;
          end
        end
        ST_SQY: begin
          if (arith_rsp.done) begin
            sq_r    <= sq_r + arith_rsp.prod[DEN_W-1:0];
            state_r <= ST_ROOT;
            go_r    <= 1'b1;
          end
        end
        ST_ROOT: begin
          if (arith_rsp.done) begin
            len_r <= arith_rsp.root;
            if (op_r == OP_END) begin
              if (arith_rsp.root > ROOT_W'(maxst_r)) begin
                state_r <= ST_CLXM;
                go_r    <= 1'b1;
              end else begin
                res_len_r <= arith_rsp.root[CFG_W-1:0];
                state_r   <= ST_EMIT;
              end
            end else if (op_r == OP_REPULSE) begin
              if (arith_rsp.root == '0) begin
                energy_r <= sat_add(energy_r, EPS, 1'b0);
                state_r  <= ST_IDLE;
              end else begin
                state_r <= ST_DSQ;
                go_r    <= 1'b1;
              end
            end else begin
              state_r <= ST_KD;
              go_r    <= 1'b1;
            end
          end
        end
        ST_DSQ: begin
          if (arith_rsp.done) begin
            sq_r    <= arith_rsp.prod[DEN_W-1:0];
            state_r <= ST_KW;
            go_r    <= 1'b1;
          end
        end
        ST_KW, ST_KD, ST_A10, ST_CXM, ST_CYM, ST_CLXM, ST_CLYM: begin
          if (arith_rsp.done) begin
            tmp_r   <= arith_rsp.prod;
            state_r <= state_t'(state_r + 1'b1);
            go_r    <= 1'b1;
          end
        end
        ST_RDIV: begin
          if (arith_rsp.done) begin
            factor_r <= quo_cap;
            tneg_r   <= 1'b0;
            energy_r <= sat_add(energy_r, quo_cap, 1'b0);
            state_r  <= ST_CXM;
            go_r     <= 1'b1;
          end
        end
        ST_ADIV: begin
          if (arith_rsp.done) begin
            factor_r <= quo_cap;
            tneg_r   <= !diff_neg;
            energy_r <= sat_add(energy_r, quo_cap, diff_neg);
            if (len_r != '0) begin
              state_r <= ST_CXM;
              go_r    <= 1'b1;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_CXD: begin
          if (arith_rsp.done) begin
            sum_x_r <= sat_add(sum_x_r, arith_rsp.quo, xneg_r ^ tneg_r);
            state_r <= ST_CYM;
            go_r    <= 1'b1;
          end
        end
        ST_CYD: begin
          if (arith_rsp.done) begin
            sum_y_r <= sat_add(sum_y_r, arith_rsp.quo, yneg_r ^ tneg_r);
            state_r <= ST_IDLE;
          end
        end
        ST_SCX: begin
          if (arith_rsp.done) begin
            ax_r    <= MAG_W'(sc_mag);
            res_x_r <= xneg_r ? 32'(-sc_mag) : sc_mag;
            state_r <= ST_SCY;
            go_r    <= 1'b1;
          end
        end
        ST_SCY: begin
          if (arith_rsp.done) begin
            ay_r    <= MAG_W'(sc_mag);
            res_y_r <= yneg_r ? 32'(-sc_mag) : sc_mag;
            state_r <= ST_SQX;
            go_r    <= 1'b1;
          end
        end
        ST_CLXD: begin
          if (arith_rsp.done) begin
            res_x_r <= xneg_r ? 32'(-{1'b0, arith_rsp.quo}) : {1'b0, arith_rsp.quo};
            state_r <= ST_CLYM;
            go_r    <= 1'b1;
          end
        end
        ST_CLYD: begin
          if (arith_rsp.done) begin
            res_y_r   <= yneg_r ? 32'(-{1'b0, arith_rsp.quo}) : {1'b0, arith_rsp.quo};
            res_len_r <= maxst_r;
            state_r   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_x_r      <= res_x_r;
            out_y_r      <= res_y_r;
            out_len_r    <= res_len_r;
            out_energy_r <= res_frz_r ? 32'd0 : energy_r;
            out_frz_r    <= res_frz_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.disp_x      = out_x_r;
  assign out_ch.disp_y      = out_y_r;
  assign out_ch.step_length = out_len_r;
  assign out_ch.energy      = out_energy_r;
  assign out_ch.was_frozen  = out_frz_r;

  `ASSERT_CLK(a_start_idle, !arith_req.start || !arith_rsp.busy, "unit started while busy")
  `ASSERT_NEXT(a_emit_load, state_r == ST_EMIT && emit_ok, out_valid_r, "result not loaded")
  `ASSERT_CLK(a_frozen_zero, !(out_valid_r && out_frz_r) || (out_x_r == '0 && out_y_r == '0 && out_len_r == '0 && out_energy_r == '0), "frozen result not zero")

endmodule

FILE: rtl/core/fld_arith.sv
// ----------------------------------------------------------------------------
// fld_arith
// Shared iterative unit: shift-add multiply, restoring divide with a 31-bit
// saturating quotient, and restoring square root, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fld_arith import fld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fld_req_t req,
  output fld_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic              sat_r;
  arith_mode_t       mode_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  x_r;
  logic [DEN_W-1:0]  y_r;

  logic [ACC_W-1:0]  mul_sum;
  logic [DEN_W:0]    div_rem;
  logic              div_ge;
  logic [DEN_W:0]    div_sub;
  logic              pre_sat;
  logic [ROOT_W+2:0] sq_rem;
  logic [ROOT_W+2:0] sq_trial;
  logic              sq_ge;

  assign mul_sum  = acc_r + (y_r[0] ? x_r : '0);
  assign div_rem  = {acc_r[DEN_W-1:0], x_r[QUO_W-1]};
  assign div_ge   = div_rem >= {1'b0, y_r};
  assign div_sub  = div_rem - {1'b0, y_r};
  assign pre_sat  = acc_r >= ACC_W'(y_r);
  assign sq_rem   = {acc_r[ROOT_W:0], x_r[DEN_W-1:DEN_W-2]};
  assign sq_trial = {1'b0, y_r[ROOT_W-1:0], 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      mode_r <= AM_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        sat_r  <= 1'b0;
        mode_r <= req.mode;
        case (req.mode)
          AM_MUL:  cnt_r <= CNT_W'(MUL_STEPS);
          AM_DIV:  cnt_r <= CNT_W'(DIV_STEPS);
          AM_SQRT: cnt_r <= CNT_W'(SQRT_STEPS);
          default: cnt_r <= CNT_W'(MUL_STEPS);
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (mode_r == AM_DIV && cnt_r == CNT_W'(DIV_STEPS) && pre_sat) begin
          sat_r  <= 1'b1;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.mode)
        AM_MUL: begin
          acc_r <= '0;
          x_r   <= ACC_W'(req.opa[MULA_W-1:0]);
          y_r   <= req.opb;
        end
        AM_DIV: begin
          acc_r <= req.opa >> QUO_W;
          x_r   <= req.opa;
          y_r   <= req.opb;
        end
        AM_SQRT: begin
          acc_r <= '0;
          x_r   <= ACC_W'(req.opb);
          y_r   <= '0;
        end
        default: begin
          acc_r <= '0;
          x_r   <= '0;
          y_r   <= '0;
        end
      endcase
    end else if (busy_r) begin
      case (mode_r)
        AM_MUL: begin
          acc_r <= mul_sum;
          x_r   <= {x_r[ACC_W-2:0], 1'b0};
          y_r   <= {1'b0, y_r[DEN_W-1:1]};
        end
        AM_DIV: begin
          if (cnt_r != CNT_W'(DIV_STEPS)) begin
            acc_r <= div_ge ? ACC_W'(div_sub) : ACC_W'(div_rem);
            x_r   <= {x_r[ACC_W-2:0], div_ge};
          end
        end
        AM_SQRT: begin
          acc_r <= sq_ge ? ACC_W'(sq_rem - sq_trial) : ACC_W'(sq_rem);
          x_r   <= {x_r[ACC_W-3:0], 2'b00};
          y_r   <= {y_r[DEN_W-2:0], sq_ge};
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.prod = acc_r;
  assign rsp.quo  = x_r[QUO_W-1:0];
  assign rsp.root = y_r[ROOT_W-1:0];

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for force_layout_displacement_core. A queue-fed driver
// sends particle transactions in bursts while the result side stalls on its
// own pattern. A bit-accurate displacement predictor checks every emitted
// result, under several register settings including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top import fld_pkg::*;;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] weight;
    logic [15:0] count;
    logic        frozen;
  } particle_item_t;

  typedef struct {
    logic [31:0] disp_x;
    logic [31:0] disp_y;
    logic [30:0] step_length;
    logic [31:0] energy;
    logic        was_frozen;
  } disp_result_t;

  localparam int          IDLE_LIMIT = 20000;
  localparam int          SETTLE     = 400;
  localparam logic [63:0] SAT_MAG    = 64'h7FFF_FFFF;
  localparam longint      EPS_UNIT   = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fld_in_if  in_ch();
  fld_out_if out_ch();

  force_layout_displacement_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  particle_item_t pending_items[$];
  disp_result_t   expected_disp[$];
  int errors = 0;

  logic [63:0] k_dist, k1_gain, k2_gain, scale_gain, step_cap;
  longint own_x, own_y, sum_x, sum_y, energy_sum;
  bit frozen_flag;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_BEGIN;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.weight = '0;
    in_ch.neighbor_count = '0;
    in_ch.frozen = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] distance(longint dx, longint dy);
    logic [65:0] sq;
    logic [69:0] rem, trial;
    logic [63:0] root;
    sq = 66'(mag(dx)) * 66'(mag(dx)) + 66'(mag(dy)) * 66'(mag(dy));
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 70'(sq[2*i +: 2]);
      trial = (70'(root) << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint along(logic [63:0] f, longint d, logic [63:0] len, bit negate);
    logic [63:0] c;
    c = f * mag(d) / len;
    return ((d < 0) != negate) ? -longint'(c) : longint'(c);
  endfunction

  task automatic predict_particle(particle_item_t it);
    longint px, py, dx, dy, diff, sx, sy;
    logic [63:0] len, dd, factor, a, f, mx, my;
    logic [127:0] quo;
    disp_result_t r;
    px = longint'(signed'(it.pos_x));
    py = longint'(signed'(it.pos_y));
    case (it.op)
      OP_BEGIN: begin
        own_x = px;
        own_y = py;
        sum_x = 0;
        sum_y = 0;
        energy_sum = 0;
        frozen_flag = it.frozen;
      end
      OP_REPULSE, OP_NEIGHBOR: begin
        dx = own_x - px;
        dy = own_y - py;
        len = distance(dx, dy);
        if (!frozen_flag && !(it.op == OP_NEIGHBOR && it.count == 0)) begin
          if (it.op == OP_REPULSE) begin
            if (len == 0) begin
              energy_sum = sat32(energy_sum + EPS_UNIT);
            end else begin
              dd = len < k_dist ? k_dist : len;
              quo = ((128'(k2_gain) * 128'(it.weight)) << 32) / (128'(dd) * 128'(dd));
              factor = quo > 128'(SAT_MAG) ? SAT_MAG : quo[63:0];
              sum_x = sat32(sum_x + along(factor, dx, len, 1'b0));
              sum_y = sat32(sum_y + along(factor, dy, len, 1'b0));
              energy_sum = sat32(energy_sum + longint'(factor));
            end
          end else begin
            diff = longint'(len) - longint'(k_dist);
            a = (k1_gain * mag(diff)) >> FRAC_BITS;
            f = a * 64'd10 / 64'(it.count);
            if (f > SAT_MAG) f = SAT_MAG;
            if (len != 0) begin
              sum_x = sat32(sum_x + along(f, dx, len, !(diff < 0)));
              sum_y = sat32(sum_y + along(f, dy, len, !(diff < 0)));
            end
            energy_sum = sat32(energy_sum + (diff < 0 ? -longint'(f) : longint'(f)));
          end
        end
      end
      default: begin
        if (frozen_flag) begin
          r = '{32'd0, 32'd0, 31'd0, 32'd0, 1'b1};
        end else begin
          mx = (mag(sum_x) * scale_gain) >> FRAC_BITS;
          my = (mag(sum_y) * scale_gain) >> FRAC_BITS;
          sx = sat32(sum_x < 0 ? -longint'(mx) : longint'(mx));
          sy = sat32(sum_y < 0 ? -longint'(my) : longint'(my));
          len = distance(sx, sy);
          if (len > step_cap) begin
            sx = along(step_cap, sx, len, 1'b0);
            sy = along(step_cap, sy, len, 1'b0);
            len = step_cap;
          end
          r = '{sx[31:0], sy[31:0], len[30:0], energy_sum[31:0], 1'b0};
        end
        expected_disp.push_back(r);
      end
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  logic in_taken = 1'b0;
  int burst_left = 10;
  int gap_left = 0;

  always @(negedge clk) begin
    logic nv;
    particle_item_t it;
    nv = in_ch.valid && !in_taken;
    if (rst_n && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_ch.op <= it.op;
        in_ch.pos_x <= it.pos_x;
        in_ch.pos_y <= it.pos_y;
        in_ch.weight <= it.weight;
        in_ch.neighbor_count <= it.count;
        in_ch.frozen <= it.frozen;
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_ch.valid <= nv;
  end

  // result-side stall pattern
  int stall_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 800);
    end
    mode_left--;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= (mode_left % 40) < 5;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    particle_item_t it;
    disp_result_t want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it = '{in_ch.op, in_ch.pos_x, in_ch.pos_y, in_ch.weight, in_ch.neighbor_count,
             in_ch.frozen};
      predict_particle(it);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_disp.size() == 0) begin
        report("unexpected result", out_ch.disp_x, 32'd0);
      end else begin
        want = expected_disp.pop_front();
        if (out_ch.disp_x !== want.disp_x) report("disp_x", out_ch.disp_x, want.disp_x);
        if (out_ch.disp_y !== want.disp_y) report("disp_y", out_ch.disp_y, want.disp_y);
        if (out_ch.step_length !== want.step_length)
          report("step_length", 32'(out_ch.step_length), 32'(want.step_length));
        if (out_ch.energy !== want.energy) report("energy", out_ch.energy, want.energy);
        if (out_ch.was_frozen !== want.was_frozen)
          report("was_frozen", 32'(out_ch.was_frozen), 32'(want.was_frozen));
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDEAL: k_dist = 64'(val);
      CFG_ATTR:  k1_gain = 64'(val);
      CFG_REPUL: k2_gain = 64'(val);
      CFG_SCALE: scale_gain = 64'(val);
      default:   step_cap = 64'(val);
    endcase
  endtask

  task automatic set_regs(logic [30:0] k, logic [30:0] k1, logic [30:0] k2,
                          logic [30:0] fs, logic [30:0] ms);
    write_reg(CFG_IDEAL, k);
    write_reg(CFG_ATTR, k1);
    write_reg(CFG_REPUL, k2);
    write_reg(CFG_SCALE, fs);
    write_reg(CFG_MAXST, ms);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_disp.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                      logic [15:0] w, logic [15:0] c, logic fz);
    particle_item_t it;
    it = '{op, px, py, w, c, fz};
    pending_items.push_back(it);
  endtask

  logic [31:0] gen_x, gen_y;

  function automatic logic [31:0] near_pos(logic [31:0] base);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return base;
      3:       return base + $urandom_range(0, 255) - 128;
      default: return base + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic push_sequence();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      push(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom), 16'($urandom),
           1'($urandom));
      return;
    end
    gen_x = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    gen_y = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    push(OP_BEGIN, gen_x, gen_y, 16'($urandom), 16'($urandom), $urandom_range(0, 4) == 0);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      push($urandom_range(0, 1) ? OP_REPULSE : OP_NEIGHBOR, near_pos(gen_x), near_pos(gen_y),
           16'($urandom), ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
           1'($urandom));
    end
    push(OP_END, $urandom, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) push_sequence();
  endtask

  initial begin
    k_dist = 64'd65536;
    k1_gain = 64'd65536;
    k2_gain = 64'd65536;
    scale_gain = 64'd65536;
    step_cap = 64'd6553600;
    own_x = 0; own_y = 0; sum_x = 0; sum_y = 0; energy_sum = 0;
    frozen_flag = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // before any begin, then extremes, coincident, zero count, frozen, repeated end
    push(OP_REPULSE, 32'h0003_0000, 32'hFFFE_0000, 16'd7, 16'd1, 1'b0);
    push(OP_NEIGHBOR, 32'h0000_8000, 32'h0001_0000, 16'd0, 16'd3, 1'b1);
    push(OP_END, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
    push(OP_BEGIN, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 1'b0);
    push(OP_REPULSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push(OP_NEIGHBOR, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'd1, 1'b1);
    push(OP_REPULSE, 32'h8000_0000, 32'h8000_0000, 16'd1, 16'd1, 1'b0);
    push(OP_NEIGHBOR, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'hFFFF, 1'b0);
    push(OP_NEIGHBOR, 32'h0000_0000, 32'h0000_0000, 16'd5, 16'd0, 1'b0);
    push(OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push(OP_END, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
    push(OP_BEGIN, 32'h0001_0000, 32'hFFFF_0000, 16'd0, 16'd1, 1'b1);
    push(OP_REPULSE, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 16'd1, 1'b0);
    push(OP_NEIGHBOR, 32'h0005_0000, 32'h0005_0000, 16'd1, 16'd2, 1'b0);
    push(OP_END, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
    push(OP_BEGIN, 32'h0000_0000, 32'h0000_0000, 16'd0, 16'd1, 1'b0);
    push(OP_REPULSE, 32'h0000_0001, 32'h0000_0000, 16'hFFFF, 16'd1, 1'b0);
    push(OP_NEIGHBOR, 32'h0064_0000, 32'h0000_0000, 16'd0, 16'd1, 1'b0);
    push(OP_END, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs(31'd65536, 31'd65536, 31'd65536, 31'd65536, 31'd6553600);
        1: set_regs(31'd0, '1, '1, '1, '1);
        2: set_regs('1, 31'd1, 31'd1, 31'd0, 31'd0);
        3: set_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                    31'($urandom));
        default: set_regs(31'($urandom_range(1, 1 << 22)), 31'($urandom_range(0, 1 << 20)),
                          31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 19)),
                          31'($urandom_range(0, 1 << 26)));
      endcase
      push_random(27);
      // hold the sender until every result is back
      while (pending_items.size() > 0 || in_ch.valid || expected_disp.size() > 0)
        @(posedge clk);
      push_random(27);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: force_layout_displacement_core.f
+incdir+rtl/core
rtl/core/fld_pkg.sv
rtl/core/fld_chan_if.sv
rtl/core/fld_arith.sv
rtl/core/force_layout_displacement_core.sv
dv/tb_top.sv
